>>> hdl/signed_radix_digit_emitter_defines.svh
// assertion macros shared by the signed radix digit emitter
`ifndef SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH

// same-cycle implication
`define SRDE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srde check failed");

// next-cycle implication
`define SRDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srde check failed");

`endif

>>> hdl/srde_pkg.sv
// shared constants and types of the signed radix digit emitter
package srde_pkg;

	localparam int NUMBER_W       = 32;
	localparam int CHAR_W         = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 64;
	localparam int BASE_LEN_W     = 5;
	localparam int CHARS_PER_REG  = 8;
	localparam int DEF_MAX_BASE   = 16;
	localparam int DEF_VALUE_BITS = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int DIV_CHUNK      = 8;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SIGN,
		BK_EMIT
	} back_state_t;

endpackage

>>> hdl/srde_queue.sv
// short fifo between the front and the back
module srde_queue #(
	parameter int W = srde_pkg::DEF_VALUE_BITS + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [W-1:0]     push_data,
	input  logic             pop,
	output logic [W-1:0]     pop_data,
	output srde_pkg::q_stat_t stat
);
	import srde_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		stat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
		stat.empty = (cnt_q == '0);
	end

	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hdl/srde_div.sv
// iterative divider by a small radix, DIV_CHUNK quotient bits per cycle
module srde_div #(
	parameter int VALUE_BITS = srde_pkg::DEF_VALUE_BITS,
	parameter int DIGIT_W    = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [DIGIT_W:0]      radix,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [DIGIT_W-1:0]    remainder
);
	import srde_pkg::*;

	localparam int STEPS = (VALUE_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
	localparam int PW    = STEPS * DIV_CHUNK;
	localparam int SC_W  = $clog2(STEPS + 1);

	logic               busy_q;
	logic               done_q;
	logic [SC_W-1:0]    cnt_q;
	logic [PW-1:0]      work_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [PW-1:0]      work_d;
	logic [DIGIT_W-1:0] rem_d;

	always_comb begin
		logic [DIGIT_W:0] t;
		logic             qb;
		work_d = work_q;
		rem_d  = rem_q;
		for (int k = 0; k < DIV_CHUNK; k++) begin
			t  = {rem_d, work_d[PW-1]};
			qb = (t >= radix);
			if (qb) begin
				t = t - radix;
			end
			rem_d  = t[DIGIT_W-1:0];
			work_d = {work_d[PW-2:0], qb};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= PW'(dividend);
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == SC_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SC_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - SC_W'(1);
				if (cnt_q == SC_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = work_q[VALUE_BITS-1:0];
	assign remainder = rem_q;

endmodule

>>> hdl/srde_front.sv
// input stage: configuration, alphabet check, sign and magnitude
module srde_front #(
	parameter int MAX_BASE   = srde_pkg::DEF_MAX_BASE,
	parameter int VALUE_BITS = srde_pkg::DEF_VALUE_BITS,
	parameter int DIGIT_W    = 4
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            cfg_write,
	input  logic [srde_pkg::CFG_IDX_W-1:0]                  cfg_index,
	input  logic [srde_pkg::CFG_DATA_W-1:0]                 cfg_data,
	input  logic                                            in_valid,
	output logic                                            in_stall,
	input  logic signed [srde_pkg::NUMBER_W-1:0]            number,
	input  srde_pkg::q_stat_t                               q_stat,
	output logic                                            q_push,
	output logic [VALUE_BITS:0]                             q_data,
	output logic [DIGIT_W:0]                                radix,
	output logic [MAX_BASE-1:0][srde_pkg::CHAR_W-1:0]       alphabet
);
	import srde_pkg::*;

	logic [BASE_LEN_W-1:0] base_len_q;
	logic [CHAR_W-1:0]     alph_q [MAX_BASE];
	logic                  ok_q;
	logic                  ok_d;
	logic                  s1_valid_s1;
	logic [VALUE_BITS-1:0] num_s1;
	logic                  take;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q <= '0;
		end else if (cfg_write && cfg_index == REG_BASE_LENGTH) begin
			base_len_q <= cfg_data[BASE_LEN_W-1:0];
		end
	end

	for (genvar i = 0; i < MAX_BASE; i++) begin : g_alph
		localparam logic [CFG_IDX_W-1:0] SEL =
			(i < CHARS_PER_REG) ? REG_ALPHABET_LOW : REG_ALPHABET_HIGH;
		localparam int LANE = i % CHARS_PER_REG;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				alph_q[i] <= '0;
			end else if (cfg_write && cfg_index == SEL) begin
				alph_q[i] <= cfg_data[LANE*CHAR_W +: CHAR_W];
			end
		end
		assign alphabet[i] = alph_q[i];
	end

	always_comb begin
		ok_d = (base_len_q >= BASE_LEN_W'(2)) && (base_len_q <= BASE_LEN_W'(MAX_BASE));
		for (int i = 0; i < MAX_BASE; i++) begin
			if (BASE_LEN_W'(i) < base_len_q) begin
				if (alph_q[i] == CHAR_NUL || alph_q[i] == CHAR_MINUS ||
				    alph_q[i] == CHAR_PLUS) begin
					ok_d = 1'b0;
				end
				for (int j = i + 1; j < MAX_BASE; j++) begin
					if (BASE_LEN_W'(j) < base_len_q && alph_q[j] == alph_q[i]) begin
						ok_d = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else begin
			ok_q <= ok_d;
		end
	end

	assign radix = base_len_q[DIGIT_W:0];

	// beats are dropped here when the alphabet is not usable
	assign take     = s1_valid_s1 && (!ok_q || !q_stat.full);
	assign q_push   = s1_valid_s1 && ok_q && !q_stat.full;
	assign in_stall = s1_valid_s1 && !take;

	assign neg    = num_s1[VALUE_BITS-1];
	assign mag    = neg ? (~num_s1 + VALUE_BITS'(1)) : num_s1;
	assign q_data = {neg, mag};

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			num_s1 <= number[VALUE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_s1 <= 1'b1;
		end else if (take) begin
			s1_valid_s1 <= 1'b0;
		end
	end

endmodule

>>> hdl/srde_back.sv
// digit extraction, digit stack and character output
`include "signed_radix_digit_emitter_defines.svh"
module srde_back #(
	parameter int MAX_BASE   = srde_pkg::DEF_MAX_BASE,
	parameter int VALUE_BITS = srde_pkg::DEF_VALUE_BITS,
	parameter int DIGIT_W    = 4
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  srde_pkg::q_stat_t                         q_stat,
	input  logic [VALUE_BITS:0]                       q_data,
	output logic                                      q_pop,
	input  logic [DIGIT_W:0]                          radix,
	input  logic [MAX_BASE-1:0][srde_pkg::CHAR_W-1:0] alphabet,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic [srde_pkg::CHAR_W-1:0]               out_char,
	output logic                                      last_char
);
	import srde_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	back_state_t           state_q;
	back_state_t           state_d;
	logic                  neg_q;
	logic [CNT_W-1:0]      depth_q;
	logic [DIGIT_W-1:0]    stack_q [VALUE_BITS];
	logic                  ov_q;
	logic [CHAR_W-1:0]     oc_q;
	logic                  ol_q;

	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quot;
	logic [DIGIT_W-1:0]    div_rem;

	logic                  slot_free;
	logic                  push_dig;
	logic                  pop_dig;
	logic                  load_out;
	logic [CHAR_W-1:0]     load_char;
	logic                  load_last;

	srde_div #(
		.VALUE_BITS(VALUE_BITS),
		.DIGIT_W   (DIGIT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.radix    (radix),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	assign slot_free = !ov_q || !out_stall;

	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		div_start    = 1'b0;
		div_dividend = div_quot;
		push_dig     = 1'b0;
		pop_dig      = 1'b0;
		load_out     = 1'b0;
		load_char    = alphabet[stack_q[0]];
		load_last    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				div_dividend = q_data[VALUE_BITS-1:0];
				if (!q_stat.empty) begin
					q_pop     = 1'b1;
					div_start = 1'b1;
					state_d   = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_done) begin
					push_dig = 1'b1;
					if (div_quot == '0 || depth_q == CNT_W'(VALUE_BITS - 1)) begin
						state_d = neg_q ? BK_SIGN : BK_EMIT;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			BK_SIGN: begin
				load_char = CHAR_MINUS;
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = BK_EMIT;
				end
			end
			BK_EMIT: begin
				load_last = (depth_q == CNT_W'(1));
				if (slot_free) begin
					load_out = 1'b1;
					pop_dig  = 1'b1;
					if (load_last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			neg_q   <= 1'b0;
			depth_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				neg_q   <= q_data[VALUE_BITS];
				depth_q <= '0;
			end else if (push_dig) begin
				depth_q <= depth_q + CNT_W'(1);
			end else if (pop_dig) begin
				depth_q <= depth_q - CNT_W'(1);
			end
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// lifo: newest digit sits at the top, so the most significant leaves first
	always_ff @(posedge clk) begin
		if (push_dig) begin
			stack_q[0] <= div_rem;
			for (int i = 1; i < VALUE_BITS; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (pop_dig) begin
			for (int i = 0; i < VALUE_BITS - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
		if (load_out) begin
			oc_q <= load_char;
			ol_q <= load_last;
		end
	end

	assign out_valid = ov_q;
	assign out_char  = oc_q;
	assign last_char = ol_q;

	`SRDE_ASSERT_IMPL(a_emit_has_digit, clk, arst_n, state_q == BK_EMIT, depth_q != '0)
	`SRDE_ASSERT_IMPL(a_done_in_div, clk, arst_n, div_done, state_q == BK_DIV)
	`SRDE_ASSERT_IMPL(a_rem_below_radix, clk, arst_n, div_done, ({1'b0, div_rem} < radix))
	`SRDE_ASSERT_NEXT(a_last_ends_number, clk, arst_n, load_out && load_last, state_q == BK_IDLE)

endmodule

>>> hdl/signed_radix_digit_emitter.sv
// top level of the signed radix digit emitter
//
//   channel   handshake                 payload
//   input     in_valid / in_stall       number
//   output    out_valid / out_stall     out_char, last_char
//   config    cfg_write                 cfg_index, cfg_data
//
// each digit is one pass of the shared divider, and each emitted character leaves
// from the output register.
// reset clears configuration, queue and control; nothing needs a clearing pass.
// a stalled output holds the back end; the two-entry queue takes beats until full.
module signed_radix_digit_emitter #(
	parameter int MAX_BASE   = srde_pkg::DEF_MAX_BASE,
	parameter int VALUE_BITS = srde_pkg::DEF_VALUE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [srde_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srde_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [srde_pkg::NUMBER_W-1:0] number,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [srde_pkg::CHAR_W-1:0]          out_char,
	output logic                                 last_char
);
	import srde_pkg::*;

	localparam int DIGIT_W = $clog2(MAX_BASE);

	q_stat_t                          q_stat;
	logic                             q_push;
	logic                             q_pop;
	logic [VALUE_BITS:0]              q_in;
	logic [VALUE_BITS:0]              q_out;
	logic [DIGIT_W:0]                 radix;
	logic [MAX_BASE-1:0][CHAR_W-1:0]  alphabet;

	srde_front #(
		.MAX_BASE  (MAX_BASE),
		.VALUE_BITS(VALUE_BITS),
		.DIGIT_W   (DIGIT_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.number   (number),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_data   (q_in),
		.radix    (radix),
		.alphabet (alphabet)
	);

	srde_queue #(
		.W(VALUE_BITS + 1)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.pop      (q_pop),
		.pop_data (q_out),
		.stat     (q_stat)
	);

	srde_back #(
		.MAX_BASE  (MAX_BASE),
		.VALUE_BITS(VALUE_BITS),
		.DIGIT_W   (DIGIT_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_data   (q_out),
		.q_pop    (q_pop),
		.radix    (radix),
		.alphabet (alphabet),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char (out_char),
		.last_char(last_char)
	);

endmodule
